FILE: sv/pnq_pkg.sv
// shared types, constants and lookup tables of the palette quantizer
`default_nettype none

package pnq_pkg;

  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam int DIST_W  = 18;
  localparam int IN_W    = 5 * CHAN_W;
  localparam int OUT_W   = 8;

  localparam logic        OP_WRITE     = 1'b0;
  localparam logic        OP_QUANTIZE  = 1'b1;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd128;
  localparam logic [DIST_W-1:0] DIST_INIT = '1;
  localparam logic [OUT_W-1:0]  TRANSPARENT_INDEX = '0;

  // c5 * 255 / 31 for every 5-bit channel value
  localparam logic [7:0] EXPAND5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  typedef struct packed {
    logic write_entry;
    logic load_pixel;
    logic scan_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic item_is_write;
    logic item_opaque;
    logic scan_last;
    logic pipe_busy;
  } status_t;

endpackage

`default_nettype wire

FILE: sv/palette_nearest_color_quantizer.sv
// top level of the nearest palette color quantizer
// a palette write gives no result; a transparent pixel skips the palette scan and its
// result is loaded from the finish state; an opaque pixel scans every palette entry
// through the single distance unit that reads one palette entry per cycle from the ram
// flow: one write per cycle while idle; a pixel holds in_tready low from its transfer until
// its result is loaded into the output register; reset: synchronous active-low rst_n clears the
// controller, output valid and the per-entry valid bits, so unwritten entries read as black
`default_nettype none

module palette_nearest_color_quantizer
  import pnq_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // entry_index, red, green, blue, alpha
  input  wire logic             in_tuser,   // operation
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [OUT_W-1:0] out_tdata   // color_index
);

  cmd_t    cmd;
  status_t status;

  pnq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  pnq_dpath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

FILE: sv/pnq_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module pnq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/pnq_ctrl.sv
// sequencing state machine of the palette quantizer
`default_nettype none

module pnq_ctrl
  import pnq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;
  logic   out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (status.item_is_write) begin
            cmd.write_entry = 1'b1;
          end else begin
            cmd.load_pixel = 1'b1;
            state_nxt = status.item_opaque ? ST_SCAN : ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/pnq_dpath.sv
// palette storage, distance pipeline and best-match tracking
`default_nettype none

module pnq_dpath
  import pnq_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IN_W-1:0]  in_tdata,
  input  wire logic             in_tuser,
  input  wire cmd_t             cmd,
  output status_t               status,
  output logic      [OUT_W-1:0] out_tdata
);

  localparam int IW = $clog2(PALETTE_ENTRIES);

  logic [7:0] f_index, f_red, f_green, f_blue, f_alpha;

  assign f_index = in_tdata[7:0];
  assign f_red   = in_tdata[15:8];
  assign f_green = in_tdata[23:16];
  assign f_blue  = in_tdata[31:24];
  assign f_alpha = in_tdata[39:32];

  logic [CHAN_W-1:0] er_r, eg_r, eb_r;
  logic              transparent_r;
  logic [IW-1:0]     scan_addr_r;
  logic [PALETTE_ENTRIES-1:0] valid_r;

  logic              wr_en;
  logic [COLOR_W-1:0] rd_data;

  logic              s1_vld_r;
  logic [IW-1:0]     s1_idx_r;
  logic              s1_live_r;

  logic              s2_vld_r;
  logic [IW-1:0]     s2_idx_r;
  logic [15:0]       s2_sqr_r, s2_sqg_r, s2_sqb_r;

  logic [DIST_W-1:0] min_err_r;
  logic [IW-1:0]     best_idx_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [COLOR_W-1:0] entry;
  logic [CHAN_W-1:0]  diff_red, diff_grn, diff_blu;
  logic [DIST_W-1:0]  sq_err;

  assign status.item_is_write = (in_tuser == OP_WRITE);
  assign status.item_opaque   = (f_alpha >= ALPHA_OPAQUE);
  assign status.scan_last     = (scan_addr_r == IW'(PALETTE_ENTRIES - 1));
  assign status.pipe_busy     = s1_vld_r || s2_vld_r;

  assign wr_en = cmd.write_entry && ({1'b0, f_index} < 9'(PALETTE_ENTRIES));

  pnq_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (f_index[IW-1:0]),
    .wr_data ({f_red, f_green, f_blue}),
    .rd_en   (cmd.scan_step),
    .rd_addr (scan_addr_r),
    .rd_data (rd_data)
  );

  // entries never written read as black
  assign entry = s1_live_r ? rd_data : '0;
  assign diff_red = (er_r > entry[23:16]) ? er_r - entry[23:16] : entry[23:16] - er_r;
  assign diff_grn = (eg_r > entry[15:8])  ? eg_r - entry[15:8]  : entry[15:8]  - eg_r;
  assign diff_blu = (eb_r > entry[7:0])   ? eb_r - entry[7:0]   : entry[7:0]   - eb_r;

  assign sq_err = DIST_W'(s2_sqr_r) + DIST_W'(s2_sqg_r) + DIST_W'(s2_sqb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[f_index[IW-1:0]] <= 1'b1;
      end
      s1_vld_r <= cmd.scan_step;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      er_r          <= EXPAND5[f_red[7:3]];
      eg_r          <= EXPAND5[f_green[7:3]];
      eb_r          <= EXPAND5[f_blue[7:3]];
      transparent_r <= !status.item_opaque;
      scan_addr_r   <= '0;
    end else if (cmd.scan_step) begin
      scan_addr_r   <= scan_addr_r + 1'b1;
    end

    s1_idx_r  <= scan_addr_r;
    s1_live_r <= valid_r[scan_addr_r];

    s2_idx_r <= s1_idx_r;
    s2_sqr_r <= 16'(diff_red) * 16'(diff_red);
    s2_sqg_r <= 16'(diff_grn) * 16'(diff_grn);
    s2_sqb_r <= 16'(diff_blu) * 16'(diff_blu);

    // strict compare keeps the lower index on equal distances
    if (cmd.load_pixel) begin
      min_err_r  <= DIST_INIT;
      best_idx_r <= '0;
    end else if (s2_vld_r && (sq_err < min_err_r)) begin
      min_err_r  <= sq_err;
      best_idx_r <= s2_idx_r;
    end

    if (cmd.load_out) begin
      out_data_r <= transparent_r ? TRANSPARENT_INDEX : OUT_W'(best_idx_r);
    end
  end

  assign out_tdata = out_data_r;

endmodule

`default_nettype wire

FILE: sim/palette_quantizer_checker.sv
// checker for the palette quantizer: watches both channels, predicts color indexes and compares
module palette_quantizer_checker
  import pnq_pkg::*;
#(
  parameter int ENTRIES = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,
  input  wire logic             in_tuser,
  input  wire logic             out_tvalid,
  input  wire logic             out_tready,
  input  wire logic [OUT_W-1:0] out_tdata,
  output int                    pending,
  output int                    errors
);

  logic [COLOR_W-1:0] palette_shadow [ENTRIES];
  logic [OUT_W-1:0]   owed_indexes [$];

  // top 5 bits of the channel scaled back to 0..255
  function automatic int expand_channel(input logic [7:0] c);
    return int'(c[7:3]) * 255 / 31;
  endfunction

  function automatic logic [OUT_W-1:0] nearest_index(input logic [7:0] r, g, b);
    int er, eg, eb, dr, dg, db, sq_err, min_err;
    logic [OUT_W-1:0] best;
    er = expand_channel(r);
    eg = expand_channel(g);
    eb = expand_channel(b);
    best = '0;
    min_err = 32'h7FFF_FFFF;
    for (int i = 0; i < ENTRIES; i++) begin
      dr = er - int'(palette_shadow[i][23:16]);
      dg = eg - int'(palette_shadow[i][15:8]);
      db = eb - int'(palette_shadow[i][7:0]);
      sq_err = dr * dr + dg * dg + db * db;
      // strict compare keeps the lowest index on equal distances
      if (sq_err < min_err) begin
        min_err = sq_err;
        best = i[OUT_W-1:0];
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    logic [7:0] idx, r, g, b, a;
    logic [OUT_W-1:0] expected;
    if (!rst_n) begin
      foreach (palette_shadow[i]) palette_shadow[i] = '0;
      owed_indexes.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        {a, b, g, r, idx} = in_tdata;
        if (in_tuser == OP_WRITE) begin
          if (int'(idx) < ENTRIES) palette_shadow[idx] = {r, g, b};
        end else if (a < ALPHA_OPAQUE) begin
          owed_indexes.push_back(TRANSPARENT_INDEX);
        end else begin
          owed_indexes.push_back(nearest_index(r, g, b));
        end
      end
      if (out_tvalid && out_tready) begin
        if (owed_indexes.size() == 0) begin
          $error("color_index: expected no transfer, actual %0d", out_tdata);
          errors <= errors + 1;
        end else begin
          expected = owed_indexes.pop_front();
          if (out_tdata !== expected) begin
            $error("color_index: expected %0d, actual %0d", expected, out_tdata);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= owed_indexes.size();
  end

endmodule

FILE: sim/tb_palette_nearest_color_quantizer.sv
// testbench top for the palette quantizer: stimulus, flow control and verdict
module tb_palette_nearest_color_quantizer;
  import pnq_pkg::*;

  localparam int ENTRIES     = 256;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_ITEMS = 260;
  localparam int HEAVY_PCT   = 76;
  localparam int BOTH_PCT    = 17;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;   // entry_index, red, green, blue, alpha
  logic             in_tuser   = 1'b0; // operation
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // color_index

  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;
  int pending;
  int errors;

  palette_nearest_color_quantizer #(
    .PALETTE_ENTRIES(ENTRIES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  palette_quantizer_checker #(
    .ENTRIES(ENTRIES)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .pending   (pending),
    .errors    (errors)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // returns at the edge of the transfer with tvalid still high
  task automatic send_item(input logic op, input logic [7:0] idx, r, g, b, a);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {a, b, g, r, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_channel(input logic coarse);
    return coarse ? 8'($urandom_range(3) * 85) : 8'($urandom_range(255));
  endfunction

  task automatic send_random_item();
    logic [7:0] idx, r, g, b, a;
    logic coarse;
    // coarse colors make duplicate palette entries and equal distances likely
    coarse = ($urandom_range(99) < 30);
    idx = 8'($urandom_range(255));
    r = pick_channel(coarse);
    g = pick_channel(coarse);
    b = pick_channel(coarse);
    if ($urandom_range(99) < 35) begin
      a = 8'($urandom_range(255));
      send_item(OP_WRITE, idx, r, g, b, a);
    end else begin
      a = ($urandom_range(99) < 80) ? 8'($urandom_range(255, 128)) : 8'($urandom_range(127));
      send_item(OP_QUANTIZE, idx, r, g, b, a);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // blank palette: every entry black, lowest index wins
    send_item(OP_QUANTIZE, 8'd17,  8'd255, 8'd255, 8'd255, 8'd255);
    send_item(OP_QUANTIZE, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
    send_item(OP_QUANTIZE, 8'd255, 8'd7,   8'd7,   8'd7,   8'd128);
    send_item(OP_QUANTIZE, 8'd3,   8'd200, 8'd100, 8'd50,  8'd127);
    // extremes of entry index and channels
    send_item(OP_WRITE,    8'd255, 8'd255, 8'd255, 8'd255, 8'd90);
    send_item(OP_WRITE,    8'd0,   8'd255, 8'd0,   8'd0,   8'd255);
    send_item(OP_QUANTIZE, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255);
    send_item(OP_QUANTIZE, 8'd255, 8'd255, 8'd0,   8'd0,   8'd255);
    // two equal entries
    send_item(OP_WRITE,    8'd10,  8'd0,   8'd0,   8'd255, 8'd0);
    send_item(OP_WRITE,    8'd20,  8'd0,   8'd0,   8'd255, 8'd0);
    send_item(OP_QUANTIZE, 8'd20,  8'd0,   8'd0,   8'd255, 8'd200);
    send_item(OP_QUANTIZE, 8'd0,   8'd0,   8'd0,   8'd0,   8'd128);
    send_item(OP_QUANTIZE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd127);
    // entry holding an exact expanded color
    send_item(OP_WRITE,    8'd128, 8'd131, 8'd139, 8'd148, 8'd170);
    send_item(OP_QUANTIZE, 8'd85,  8'd135, 8'd143, 8'd150, 8'd255);
    send_item(OP_WRITE,    8'd170, 8'd85,  8'd170, 8'd85,  8'd255);
    send_item(OP_QUANTIZE, 8'd170, 8'd88,  8'd170, 8'd85,  8'd129);
    wait_results_drained();

    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? HEAVY_PCT : (p == 3) ? BOTH_PCT : 0;
      stall_pct <= (p == 2) ? HEAVY_PCT : (p == 3) ? BOTH_PCT : 0;
      repeat (PHASE_ITEMS) send_random_item();
      wait_results_drained();
    end

    repeat (ENTRIES + 16) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
